@@ rtl/core/lzrle_pkg.sv @@
// ----------------------------------------------------------------------------
// lzrle_pkg: shared types and constants of the lz/rle byte decompressor
// word formats, decode phases, command kinds and history window sizing
// ----------------------------------------------------------------------------
package lzrle_pkg;

  localparam int unsigned WinDepth  = 1024;
  localparam int unsigned WinAw     = $clog2(WinDepth);
  localparam int unsigned DistW     = WinAw + 1;
  localparam int unsigned CntW      = 15;
  localparam int unsigned ChunkLenW = 7;
  localparam int unsigned RepsW     = 9;
  localparam int unsigned ByteCntW  = 32;
  localparam int unsigned PaddrW    = 2;

  typedef enum logic [3:0] {
    PH_CMD        = 4'd0,
    PH_RUN_EXT    = 4'd1,
    PH_RUN_DATA   = 4'd2,
    PH_RUN_EMIT   = 4'd3,
    PH_COPY_DIST  = 4'd4,
    PH_COPY_EMIT  = 4'd5,
    PH_CHUNK_REPS = 4'd6,
    PH_CHUNK_DATA = 4'd7,
    PH_LIT_EXT    = 4'd8,
    PH_LIT_DATA   = 4'd9
  } phase_e;

  // two top bits of a command byte
  typedef enum logic [1:0] {
    KIND_LIT   = 2'b00,
    KIND_CHUNK = 2'b01,
    KIND_COPY  = 2'b10,
    KIND_RUN   = 2'b11
  } kind_e;

  typedef struct packed {
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
  } step_in_t;

  typedef struct packed {
    logic       in_taken;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       done_res;
    logic       error;
  } step_out_t;

  typedef struct packed {
    logic             we;
    logic [WinAw-1:0] waddr;
    logic [7:0]       wdata;
    logic [WinAw-1:0] raddr;
  } win_req_t;

endpackage

@@ rtl/core/lzrle_cfg.sv @@
// ----------------------------------------------------------------------------
// lzrle_cfg: configuration register file
// apb-style slave holding the expected output size
// ----------------------------------------------------------------------------
module lzrle_cfg import lzrle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PaddrW-1:0]   paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [ByteCntW-1:0] output_size_o
);

  logic [ByteCntW-1:0] osize_q, osize_d;
  logic                wr_en;

  // single register: every byte offset maps to it
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign osize_d = wr_en ? pwdata : osize_q;
  assign prdata  = (paddr[PaddrW-1:0] == '0 || 1'b1) ? osize_q : '0;
  assign output_size_o = osize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      osize_q <= '0;
    end else begin
      osize_q <= osize_d;
    end
  end

endmodule

@@ rtl/core/lzrle_window.sv @@
// ----------------------------------------------------------------------------
// lzrle_window: history window memory
// one write and one registered read per cycle, same-address write bypass
// ----------------------------------------------------------------------------
module lzrle_window import lzrle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  win_req_t   req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem [WinDepth];
  logic [7:0] mem_rdata_q;
  logic [7:0] byp_data_q;
  logic       byp_q, byp_d;

  assign byp_d = req_i.we && (req_i.waddr == req_i.raddr);

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    mem_rdata_q <= mem[req_i.raddr];
    byp_data_q  <= req_i.wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= byp_d;
    end
  end

  assign rdata_o = byp_q ? byp_data_q : mem_rdata_q;

endmodule

@@ rtl/core/lzrle_core.sv @@
// ----------------------------------------------------------------------------
// lzrle_core: decode state machine
// one decode step per enable, window write and next-step read prefetch
// ----------------------------------------------------------------------------
module lzrle_core import lzrle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_en_i,
  input  step_in_t            step_i,
  input  logic [ByteCntW-1:0] output_size_i,
  input  logic [7:0]          win_rdata_i,
  output win_req_t            win_req_o,
  output step_out_t           result_o
);

  phase_e                 ph_q, ph_d;
  logic [ByteCntW-1:0]    bw_q, bw_d;
  logic [7:0]             cmd_q, cmd_d;
  logic [CntW-1:0]        remain_q, remain_d;
  logic [DistW-1:0]       dist_q, dist_d;
  logic [7:0]             fill_q, fill_d;
  logic [ChunkLenW-1:0]   clen_q, clen_d;
  logic [RepsW-1:0]       reps_q, reps_d;
  logic                   ended_q, ended_d;
  logic                   fin_q, fin_d;
  logic                   err_q, err_d;

  logic                   active, needs_input;
  logic                   finish_now, err_now, emit_now, take_now, lit_now, put;
  logic [7:0]             emit_val, put_val, b;
  logic [DistW-1:0]       copy_dist_raw;
  logic [CntW-1:0]        chunk_copy_len;
  logic [ByteCntW-1:0]    bw_inc, rd_diff;

  assign b           = step_i.in_byte;
  assign active      = !fin_q && !err_q;
  assign needs_input = (ph_q != PH_RUN_EMIT) && (ph_q != PH_COPY_EMIT);
  assign finish_now  = active && (ph_q == PH_CMD) && (bw_q >= output_size_i);
  assign err_now     = active && !finish_now && needs_input && ended_q;
  assign emit_now    = active && !finish_now && !needs_input;
  assign take_now    = active && !finish_now && needs_input && !ended_q && step_i.in_valid;
  assign lit_now     = take_now && ((ph_q == PH_CHUNK_DATA) || (ph_q == PH_LIT_DATA));
  assign put         = emit_now || lit_now;

  assign emit_val = (ph_q == PH_COPY_EMIT) ? ((dist_q == '0) ? 8'h00 : win_rdata_i) : fill_q;
  assign put_val  = emit_now ? emit_val : b;
  assign bw_inc   = bw_q + ByteCntW'(1);

  assign copy_dist_raw  = DistW'({cmd_q[1:0], b}) + DistW'(1);
  assign chunk_copy_len = CntW'(8'(reps_q - RepsW'(1))) * CntW'(clen_q);

  // next state
  always_comb begin
    ph_d     = ph_q;
    bw_d     = bw_q;
    cmd_d    = cmd_q;
    remain_d = remain_q;
    dist_d   = dist_q;
    fill_d   = fill_q;
    clen_d   = clen_q;
    reps_d   = reps_q;
    ended_d  = ended_q;
    fin_d    = fin_q;
    err_d    = err_q;
    if (step_en_i) begin
      if (finish_now) begin
        fin_d = 1'b1;
      end else if (err_now) begin
        err_d = 1'b1;
      end else if (emit_now) begin
        bw_d     = bw_inc;
        remain_d = remain_q - CntW'(1);
        if (remain_q == CntW'(1)) begin
          ph_d = PH_CMD;
        end
      end else if (take_now) begin
        if (step_i.in_last) begin
          ended_d = 1'b1;
        end
        case (ph_q)
          PH_CMD: begin
            cmd_d = b;
            case (kind_e'(b[7:6]))
              KIND_RUN: begin
                remain_d = CntW'(b[4:0]) + CntW'(2);
                ph_d     = b[5] ? PH_RUN_EXT : PH_RUN_DATA;
              end
              KIND_COPY: begin
                remain_d = CntW'(b[5:2]) + CntW'(2);
                ph_d     = PH_COPY_DIST;
              end
              KIND_CHUNK: begin
                clen_d = ChunkLenW'(b[5:0]) + ChunkLenW'(2);
                ph_d   = PH_CHUNK_REPS;
              end
              default: begin
                remain_d = CntW'(b[4:0]) + CntW'(1);
                ph_d     = b[5] ? PH_LIT_EXT : PH_LIT_DATA;
              end
            endcase
          end
          PH_RUN_EXT: begin
            remain_d = remain_q + CntW'({b, 5'b0});
            ph_d     = PH_RUN_DATA;
          end
          PH_RUN_DATA: begin
            fill_d = b;
            ph_d   = PH_RUN_EMIT;
          end
          PH_COPY_DIST: begin
            // a copy reaching before the first byte yields zeros
            dist_d = (ByteCntW'(copy_dist_raw) > bw_q) ? '0 : copy_dist_raw;
            ph_d   = PH_COPY_EMIT;
          end
          PH_CHUNK_REPS: begin
            reps_d   = RepsW'(b) + RepsW'(1);
            remain_d = CntW'(clen_q);
            ph_d     = PH_CHUNK_DATA;
          end
          PH_LIT_EXT: begin
            remain_d = remain_q + CntW'({b, 5'b0});
            ph_d     = PH_LIT_DATA;
          end
          PH_CHUNK_DATA, PH_LIT_DATA: begin
            bw_d     = bw_inc;
            remain_d = remain_q - CntW'(1);
            if (remain_q == CntW'(1)) begin
              ph_d = PH_CMD;
              if ((ph_q == PH_CHUNK_DATA) && (reps_q > RepsW'(1))) begin
                remain_d = chunk_copy_len;
                dist_d   = (ByteCntW'(clen_q) > bw_inc) ? '0 : DistW'(clen_q);
                ph_d     = PH_COPY_EMIT;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // step result and window access
  always_comb begin
    result_o.in_taken  = take_now;
    result_o.out_valid = put;
    result_o.out_byte  = put ? put_val : 8'h00;
    result_o.done_res  = fin_d;
    result_o.error     = err_d;
  end

  // prefetch the byte the next step would copy
  assign rd_diff         = bw_d - ByteCntW'(dist_d);
  assign win_req_o.we    = step_en_i && put;
  assign win_req_o.waddr = bw_q[WinAw-1:0];
  assign win_req_o.wdata = put_val;
  assign win_req_o.raddr = rd_diff[WinAw-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q     <= PH_CMD;
      bw_q     <= '0;
      cmd_q    <= '0;
      remain_q <= '0;
      dist_q   <= '0;
      fill_q   <= '0;
      clen_q   <= '0;
      reps_q   <= '0;
      ended_q  <= 1'b0;
      fin_q    <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      ph_q     <= ph_d;
      bw_q     <= bw_d;
      cmd_q    <= cmd_d;
      remain_q <= remain_d;
      dist_q   <= dist_d;
      fill_q   <= fill_d;
      clen_q   <= clen_d;
      reps_q   <= reps_d;
      ended_q  <= ended_d;
      fin_q    <= fin_d;
      err_q    <= err_d;
    end
  end

endmodule

@@ rtl/core/lz_rle_byte_decompressor_top.sv @@
// ----------------------------------------------------------------------------
// lz_rle_byte_decompressor_top: byte-serial lz77 / run-length decompressor
// input word register, decode core with history window, result word register
// ----------------------------------------------------------------------------
// Each input word is one decode step: it offers (or not) one compressed byte,
// and each step returns exactly one result word telling whether the byte was
// taken, the decompressed byte emitted in that step if any, and the done and
// error flags. The block takes one word per clock and returns one result per
// clock while the result side drains; a word passes the input register, then
// the result register, and the decode loop through the state registers
// sets that rate. Copy bytes come from a 1024-byte history window whose read
// is prefetched one step ahead with a bypass for the byte written in the
// same cycle, so overlapping copies run at full rate. The window needs no
// clearing pass after reset: a copy that would reach before the first output
// byte is turned into zeros, so no unwritten entry's byte is ever used. Write
// output_size (byte address 0) while the block is idle.
// ----------------------------------------------------------------------------
module lz_rle_byte_decompressor_top import lzrle_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // compressed step words
  input  logic              s_valid_i,
  output logic              s_ready_o,
  input  step_in_t          s_word_i,
  // result words
  output logic              m_valid_o,
  input  logic              m_ready_i,
  output step_out_t         m_word_o,
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  step_in_t            in_q;
  step_out_t           out_q, result;
  logic                in_full_q, in_full_d;
  logic                out_full_q, out_full_d;
  logic                advance, s_acc;
  logic [ByteCntW-1:0] output_size;
  logic [7:0]          win_rdata;
  win_req_t            win_req;

  // a step moves on when the result slot is free or being drained
  assign advance    = in_full_q && (!out_full_q || m_ready_i);
  assign s_ready_o  = !in_full_q || advance;
  assign s_acc      = s_valid_i && s_ready_o;
  assign in_full_d  = s_acc || (in_full_q && !advance);
  assign out_full_d = advance || (out_full_q && !m_ready_i);

  lzrle_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .output_size_o (output_size)
  );

  lzrle_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_en_i     (advance),
    .step_i        (in_q),
    .output_size_i (output_size),
    .win_rdata_i   (win_rdata),
    .win_req_o     (win_req),
    .result_o      (result)
  );

  lzrle_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (win_req),
    .rdata_o (win_rdata)
  );

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_q <= s_word_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  // occupancy flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q  <= 1'b0;
      out_full_q <= 1'b0;
    end else begin
      in_full_q  <= in_full_d;
      out_full_q <= out_full_d;
    end
  end

  assign m_valid_o = out_full_q;
  assign m_word_o  = out_q;

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the lz/rle byte decompressor
// ----------------------------------------------------------------------------
// Drives decode steps into the block, one step word per handshake. The step
// content comes from a queue of compressed bytes built from whole commands
// (literal runs, byte runs, back-copies, chunk repeats); a byte stays offered
// until the decoder takes it. A scoreboard class predicts the result word of
// every accepted step from its own copy of the decoder state, and each result
// word is compared field by field with the oldest prediction. The run goes
// through several output_size settings and ends the stream in one of several
// ways chosen at random: done exactly, done after an overshooting command,
// done after a late size write, error at a command boundary, error mid-command.
// ----------------------------------------------------------------------------
module testbench;
  import lzrle_pkg::*;

  localparam int unsigned HalfPeriod = 10;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned CycleLimit = 1_500_000;
  localparam int unsigned IdlePercent = 34;
  localparam int unsigned HoldAt = 600;        // results seen before the long hold-off
  localparam int unsigned HoldCycles = 400;
  localparam logic [PaddrW-1:0] AddrOutputSize = '0;

  // ways the compressed stream ends
  typedef enum int unsigned {
    END_EXACT,
    END_OVERSHOOT,
    END_LATE_WRITE,
    END_ERROR_BOUNDARY,
    END_ERROR_MIDCMD
  } finale_e;

  // --------------------------------------------------------------------------
  // scoreboard: decoder state copy, predicted result words, comparison
  // --------------------------------------------------------------------------
  class decode_scoreboard;
    bit [7:0]           history [WinDepth];
    bit [ByteCntW-1:0]  out_count;
    bit [ByteCntW-1:0]  size_limit;
    phase_e             phase;
    bit [7:0]           cmd_byte;
    bit [CntW-1:0]      left;
    bit [DistW-1:0]     copy_dist;
    bit [7:0]           fill;
    bit [ChunkLenW-1:0] chunk_len;
    bit [RepsW-1:0]     chunk_reps;
    bit                 stream_over;
    bit                 finished;
    bit                 failed;
    step_out_t          awaited [$];
    int unsigned        checked;
    int unsigned        mismatches;

    function new();
      phase = PH_CMD;
    endfunction

    function void note_output(bit [7:0] v);
      history[out_count[WinAw-1:0]] = v;
      out_count++;
    endfunction

    // advance the decoder copy by one accepted step, queue its result word
    function bit predict_step(step_in_t w);
      step_out_t r;
      phase_e was;
      bit [31:0] span;
      bit [7:0] v;
      bit needs_byte;
      r = '0;
      was = phase;
      needs_byte = (phase != PH_RUN_EMIT) && (phase != PH_COPY_EMIT);
      if (!finished && !failed) begin
        if (phase == PH_CMD && out_count >= size_limit) begin
          finished = 1'b1;
        end else if (needs_byte && stream_over) begin
          failed = 1'b1;
        end else if (!needs_byte) begin
          v = fill;
          if (phase == PH_COPY_EMIT) begin
            span = out_count - ByteCntW'(copy_dist);
            v = (copy_dist == '0) ? 8'h00 : history[span[WinAw-1:0]];
          end
          r.out_valid = 1'b1;
          r.out_byte = v;
          note_output(v);
          left = left - CntW'(1);
          if (left == '0) phase = PH_CMD;
        end else if (w.in_valid) begin
          r.in_taken = 1'b1;
          if (w.in_last) stream_over = 1'b1;
          case (phase)
            PH_CMD: begin
              cmd_byte = w.in_byte;
              case (kind_e'(w.in_byte[7:6]))
                KIND_RUN: begin
                  left = CntW'(w.in_byte[4:0]) + CntW'(2);
                  phase = w.in_byte[5] ? PH_RUN_EXT : PH_RUN_DATA;
                end
                KIND_COPY: begin
                  left = CntW'(w.in_byte[5:2]) + CntW'(2);
                  phase = PH_COPY_DIST;
                end
                KIND_CHUNK: begin
                  chunk_len = ChunkLenW'(w.in_byte[5:0]) + ChunkLenW'(2);
                  phase = PH_CHUNK_REPS;
                end
                default: begin
                  left = CntW'(w.in_byte[4:0]) + CntW'(1);
                  phase = w.in_byte[5] ? PH_LIT_EXT : PH_LIT_DATA;
                end
              endcase
            end
            PH_RUN_EXT: begin
              left = left + CntW'({w.in_byte, 5'd0});
              phase = PH_RUN_DATA;
            end
            PH_LIT_EXT: begin
              left = left + CntW'({w.in_byte, 5'd0});
              phase = PH_LIT_DATA;
            end
            PH_RUN_DATA: begin
              fill = w.in_byte;
              phase = PH_RUN_EMIT;
            end
            PH_COPY_DIST: begin
              span = 32'({cmd_byte[1:0], w.in_byte}) + 32'd1;
              copy_dist = (span > out_count) ? '0 : span[DistW-1:0];
              phase = PH_COPY_EMIT;
            end
            PH_CHUNK_REPS: begin
              chunk_reps = RepsW'(w.in_byte) + RepsW'(1);
              left = CntW'(chunk_len);
              phase = PH_CHUNK_DATA;
            end
            PH_CHUNK_DATA, PH_LIT_DATA: begin
              r.out_valid = 1'b1;
              r.out_byte = w.in_byte;
              note_output(w.in_byte);
              left = left - CntW'(1);
              if (left == '0) begin
                phase = PH_CMD;
                if (was == PH_CHUNK_DATA && chunk_reps > RepsW'(1)) begin
                  // chunk written once, the repeats copy it from its own length back
                  span = 32'(chunk_reps - RepsW'(1)) * 32'(chunk_len);
                  left = span[CntW-1:0];
                  copy_dist = (ByteCntW'(chunk_len) > out_count) ? '0 : DistW'(chunk_len);
                  phase = PH_COPY_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      r.done_res = finished;
      r.error = failed;
      awaited.push_back(r);
      return r.in_taken;
    endfunction

    function void compare_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        mismatches++;
      end
    endfunction

    function void check_step(step_out_t got);
      step_out_t want;
      checked++;
      if (awaited.size() == 0) begin
        $display("%0t: result word expected none actual %0h", $time, got);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      compare_field("in_taken", 32'(want.in_taken), 32'(got.in_taken));
      compare_field("out_valid", 32'(want.out_valid), 32'(got.out_valid));
      compare_field("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
      compare_field("error", 32'(want.error), 32'(got.error));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block ports, the driven ones at known values from time zero
  // --------------------------------------------------------------------------
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_valid_i = 1'b0;
  logic              s_ready_o;
  step_in_t          s_word_i = '0;
  logic              m_valid_o;
  logic              m_ready_i = 1'b0;
  step_out_t         m_word_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [PaddrW-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  decode_scoreboard board = new();

  // compressed bytes still to be offered: bit 8 marks the last byte of the stream
  logic [8:0] code_bytes [$];

  // no random idling on either side while set
  bit calm = 1'b0;

  int unsigned cycles = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  lz_rle_byte_decompressor_top dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_valid_i),
    .s_ready_o (s_ready_o),
    .s_word_i  (s_word_i),
    .m_valid_o (m_valid_o),
    .m_ready_i (m_ready_i),
    .m_word_o  (m_word_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // --------------------------------------------------------------------------
  // command encoders: append one whole command to the compressed byte queue
  // --------------------------------------------------------------------------

  // literal run of n bytes (1..8192); wide forces the extension byte
  function automatic void add_literal(int unsigned n, bit wide);
    logic [12:0] m;
    bit ext;
    m = 13'(n - 1);
    ext = wide || (m > 13'd31);
    code_bytes.push_back({1'b0, KIND_LIT, ext, m[4:0]});
    if (ext) code_bytes.push_back({1'b0, m[12:5]});
    repeat (n) code_bytes.push_back({1'b0, 8'($urandom)});
  endfunction

  // byte run of n copies (2..8193)
  function automatic void add_run(int unsigned n, logic [7:0] value, bit wide);
    logic [12:0] m;
    bit ext;
    m = 13'(n - 2);
    ext = wide || (m > 13'd31);
    code_bytes.push_back({1'b0, KIND_RUN, ext, m[4:0]});
    if (ext) code_bytes.push_back({1'b0, m[12:5]});
    code_bytes.push_back({1'b0, value});
  endfunction

  // back-copy of len bytes (2..17) from offset bytes back (1..1024)
  function automatic void add_copy(int unsigned len, int unsigned offset);
    logic [3:0] l;
    logic [9:0] d;
    l = 4'(len - 2);
    d = 10'(offset - 1);
    code_bytes.push_back({1'b0, KIND_COPY, l, d[9:8]});
    code_bytes.push_back({1'b0, d[7:0]});
  endfunction

  // chunk of len bytes (2..65) repeated reps times (1..256)
  function automatic void add_chunk(int unsigned len, int unsigned reps);
    code_bytes.push_back({1'b0, KIND_CHUNK, 6'(len - 2)});
    code_bytes.push_back({1'b0, 8'(reps - 1)});
    repeat (len) code_bytes.push_back({1'b0, 8'($urandom)});
  endfunction

  // mostly short commands, one in twenty large (copies are never large)
  function automatic void add_random_command();
    bit big;
    big = ($urandom_range(19) == 0);
    case (kind_e'($urandom_range(3)))
      KIND_LIT: add_literal(big ? $urandom_range(120, 33) : $urandom_range(40, 1),
                            $urandom_range(3) == 0);
      KIND_RUN: add_run(big ? $urandom_range(150, 34) : $urandom_range(40, 2),
                        8'($urandom), $urandom_range(3) == 0);
      KIND_COPY: add_copy($urandom_range(17, 2),
                          ($urandom_range(3) == 0) ? $urandom_range(4, 1)
                                                   : $urandom_range(1024, 1));
      default: add_chunk($urandom_range(65, 2),
                         big ? $urandom_range(12, 9) : $urandom_range(4, 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------

  // config write then read back, both in setup and access cycles
  task automatic set_output_size(logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrOutputSize;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    // register written at this edge, read it back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    board.compare_field("output_size", value, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
    board.size_limit = value;
  endtask

  // hold the word until the block takes it, then predict its result
  task automatic offer_word(input step_in_t w, output bit taken);
    s_valid_i <= 1'b1;
    s_word_i <= w;
    do @(posedge clk_i); while (s_ready_o !== 1'b1);
    taken = board.predict_step(w);
  endtask

  // one decode step: offers the head compressed byte most of the time,
  // otherwise a word with no byte and junk in the other fields
  task automatic do_step();
    step_in_t w;
    bit taken;
    w.in_valid = (code_bytes.size() != 0) && ($urandom_range(99) >= 10);
    w.in_byte = w.in_valid ? code_bytes[0][7:0] : 8'($urandom);
    w.in_last = w.in_valid ? code_bytes[0][8] : 1'($urandom);
    while (!calm && $urandom_range(99) < IdlePercent) begin
      s_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    offer_word(w, taken);
    if (taken) void'(code_bytes.pop_front());
  endtask

  // step until the queue is empty and the decoder is back at a command
  // boundary; with top_up, random commands are added until min_steps are done
  task automatic pump_stream(int unsigned min_steps, bit top_up);
    int unsigned n;
    n = 0;
    while (code_bytes.size() != 0 || board.phase != PH_CMD || (top_up && n < min_steps)) begin
      if (top_up && code_bytes.size() == 0 && n < min_steps) add_random_command();
      do_step();
      n++;
    end
  endtask

  // let every predicted word come back before touching the register
  task automatic await_idle();
    s_valid_i <= 1'b0;
    while (board.awaited.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // result side: checks every accepted word, random back-pressure with one
  // long hold-off so the block fills up and stalls its input
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall_left;
    bit held;
    stall_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_valid_o === 1'b1 && m_ready_i) board.check_step(m_word_o);
      if (!held && board.checked >= HoldAt) begin
        held = 1'b1;
        stall_left = HoldCycles;
      end
      if (stall_left != 0) begin
        m_ready_i <= 1'b0;
        stall_left--;
      end else begin
        m_ready_i <= calm || ($urandom_range(99) >= IdlePercent);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    finale_e finale;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // both extremes of the size register; the decoder stays open with all ones
    set_output_size('0);
    set_output_size('1);

    // directed commands, the first ones reach before the first output byte
    add_copy(17, 1024);
    add_copy(4, 100);
    add_literal(1, 1'b0);
    add_copy(2, 1);                // overlapping copy, repeats the last byte
    add_chunk(2, 1);               // chunk with no repeat
    add_chunk(3, 2);
    add_literal(32, 1'b0);
    add_literal(5, 1'b1);          // extension byte of zero
    add_run(2, 8'h00, 1'b0);
    add_run(33, 8'hFF, 1'b1);
    add_literal(40, 1'b0);         // count needs the extension byte
    add_run(60, 8'hA5, 1'b0);
    add_copy(17, 200);             // far back into the output so far
    add_copy(2, 1024);
    add_copy(5, 3);
    add_chunk(10, 4);
    add_chunk(65, 1);              // longest chunk
    pump_stream(0, 1'b0);

    // random commands under a mid-range size, first without any idling
    await_idle();
    set_output_size($urandom_range(32'h7FFF_FFFF, 32'h4000_0000));
    calm = 1'b1;
    pump_stream(250, 1'b1);
    calm = 1'b0;
    pump_stream(250, 1'b1);

    await_idle();
    set_output_size('1);
    pump_stream(200, 1'b1);

    // end of the stream
    await_idle();
    finale = finale_e'($urandom_range(4));
    case (finale)
      END_EXACT: begin
        set_output_size($urandom_range(1) ? board.out_count : '0);
      end
      END_OVERSHOOT: begin
        // the run completes even past the size
        set_output_size(board.out_count + $urandom_range(10, 1));
        add_run($urandom_range(40, 12), 8'($urandom), 1'b0);
        pump_stream(0, 1'b0);
      end
      END_LATE_WRITE: begin
        // size written mid-command applies at the next boundary
        add_literal(30, 1'b0);
        repeat (12) do_step();
        await_idle();
        set_output_size(board.out_count);
        pump_stream(0, 1'b0);
      end
      END_ERROR_BOUNDARY: begin
        // stream ends after a whole command with output still short
        add_random_command();
        code_bytes[code_bytes.size() - 1][8] = 1'b1;
        pump_stream(0, 1'b0);
      end
      default: begin
        // stream ends on a copy command byte, its distance never comes
        code_bytes.push_back({1'b1, KIND_COPY, 6'($urandom)});
      end
    endcase
    // once stopped, offered bytes are neither taken nor decoded
    repeat (8) code_bytes.push_back({1'b0, 8'($urandom)});
    repeat (24) do_step();

    await_idle();
    repeat (8) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
